// ----- rtl/vbfp_pkg.sv -----
package vbfp_pkg;

  localparam logic [15:0] WORD_START      = 16'haa55;
  localparam logic [15:0] WORD_START_CC   = 16'haa56;
  localparam logic [15:0] WORD_START_SWAP = 16'h55aa;
  localparam logic [15:0] WORD_NONE       = 16'hffff;
  localparam logic [15:0] WORD_ZERO       = 16'h0000;

  localparam int unsigned IDX_W = 3;
  localparam logic [IDX_W-1:0] FIELD_FIRST = 3'd0;
  localparam logic [IDX_W-1:0] FIELD_LAST  = 3'd4;

  typedef enum logic [1:0] {
    KIND_BLOCK   = 2'd0,
    KIND_END     = 2'd1,
    KIND_CKERR   = 2'd2,
    KIND_SYNCERR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_FIELD,
    OP_BLOCK,
    OP_END,
    OP_CKERR,
    OP_SYNCERR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [15:0]      word;
    logic             colour;
  } cmd_t;

endpackage

// ----- rtl/vbfp_if.sv -----
interface vbfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface vbfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] signature;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic        colour_code;

  modport source (output valid, output kind, output signature, output pos_x, output pos_y,
                  output box_width, output box_height, output colour_code, input ready);
  modport sink (input valid, input kind, input signature, input pos_x, input pos_y,
                input box_width, input box_height, input colour_code, output ready);
endinterface

// ----- rtl/vision_block_frame_parser.sv -----
// Frame parser for a camera's serial byte link.
// The in_bus channel carries one received byte per word, low byte of each
// 16-bit word first. The out_bus channel carries one result per word: a
// checked block with its five field words, a frame end, a checksum abort or
// a sync abort, with the colour-code flag of the latest start word.
// The front end pairs bytes, hunts for the start sequence, tracks the block
// layout and its running sum, and posts commands into a two-entry queue.
// The back end keeps the field words and owns the output register.
// One byte is accepted every cycle while the queue is not full. A result
// is registered first in the queue and then in the output register, which
// drives it on out_bus.
// If the receiver stalls, the result holds in the output register, the queue
// fills behind it, and in_bus.ready drops only once the queue is full; field
// words still drain into the back end while the output waits.
// Synchronous reset returns the parser to hunting for a start sequence on a
// low byte, empties the queue and clears the output valid flag.
module vision_block_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  vbfp_in_if.sink     in_bus,
  vbfp_out_if.source  out_bus
);

  logic           q_full;
  logic           push;
  vbfp_pkg::cmd_t push_cmd;
  logic           pop;
  logic           q_valid;
  vbfp_pkg::cmd_t q_cmd;

  vbfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_byte  (in_bus.data_byte),
    .in_ready (in_bus.ready),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  vbfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  vbfp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

// ----- rtl/vbfp_front.sv -----
module vbfp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_ready,
  input  logic                q_full,
  output logic                push,
  output vbfp_pkg::cmd_t      push_cmd
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_CHECK,
    ST_FIELDS,
    ST_SYNC
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         phase_r, phase_nxt;
  logic [7:0]                   low_r, low_nxt;
  logic                         drop_r, drop_nxt;
  logic [15:0]                  prev_r, prev_nxt;
  logic [vbfp_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [15:0]                  check_r, check_nxt;
  logic [15:0]                  sum_r, sum_nxt;
  logic                         colour_r, colour_nxt;
  logic                         take;
  logic [15:0]                  word;
  logic [15:0]                  sum_add;
  logic                         is_start;
  logic                         is_cc;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign word     = {in_byte, low_r};
  assign sum_add  = sum_r + word;
  assign is_start = (word == vbfp_pkg::WORD_START);
  assign is_cc    = (word == vbfp_pkg::WORD_START_CC);

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    low_nxt         = low_r;
    drop_nxt        = drop_r;
    prev_nxt        = prev_r;
    idx_nxt         = idx_r;
    check_nxt       = check_r;
    sum_nxt         = sum_r;
    colour_nxt      = colour_r;
    push            = 1'b0;
    push_cmd.op     = vbfp_pkg::OP_FIELD;
    push_cmd.idx    = idx_r;
    push_cmd.word   = word;
    if (take) begin
      if (drop_r) begin
        drop_nxt = 1'b0;
      end else if (!phase_r) begin
        low_nxt   = in_byte;
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        case (state_r)
          ST_CHECK: begin
            if (is_start || is_cc) begin
              colour_nxt  = is_cc;
              push        = 1'b1;
              push_cmd.op = vbfp_pkg::OP_END;
            end else if (word == vbfp_pkg::WORD_ZERO) begin
              state_nxt   = ST_HUNT;
              prev_nxt    = vbfp_pkg::WORD_NONE;
              push        = 1'b1;
              push_cmd.op = vbfp_pkg::OP_END;
            end else begin
              check_nxt = word;
              sum_nxt   = 16'h0000;
              idx_nxt   = vbfp_pkg::FIELD_FIRST;
              state_nxt = ST_FIELDS;
            end
          end
          ST_FIELDS: begin
            sum_nxt = sum_add;
            push    = 1'b1;
            if (idx_r != vbfp_pkg::FIELD_LAST) begin
              idx_nxt = idx_r + 1'b1;
            end else begin
              idx_nxt = vbfp_pkg::FIELD_FIRST;
              if (sum_add == check_r) begin
                state_nxt   = ST_SYNC;
                push_cmd.op = vbfp_pkg::OP_BLOCK;
              end else begin
                state_nxt   = ST_HUNT;
                prev_nxt    = vbfp_pkg::WORD_NONE;
                push_cmd.op = vbfp_pkg::OP_CKERR;
              end
            end
          end
          ST_SYNC: begin
            if (is_start || is_cc) begin
              colour_nxt = is_cc;
              state_nxt  = ST_CHECK;
            end else begin
              state_nxt   = ST_HUNT;
              prev_nxt    = vbfp_pkg::WORD_NONE;
              push        = 1'b1;
              push_cmd.op = vbfp_pkg::OP_SYNCERR;
            end
          end
          default: begin
            if (prev_r == vbfp_pkg::WORD_START && (is_start || is_cc)) begin
              colour_nxt = is_cc;
              state_nxt  = ST_CHECK;
            end else if (word == vbfp_pkg::WORD_START_SWAP) begin
              drop_nxt = 1'b1;
            end
            prev_nxt = word;
          end
        endcase
      end
    end
    push_cmd.colour = colour_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT;
      phase_r  <= 1'b0;
      low_r    <= 8'h00;
      drop_r   <= 1'b0;
      prev_r   <= vbfp_pkg::WORD_NONE;
      idx_r    <= vbfp_pkg::FIELD_FIRST;
      check_r  <= 16'h0000;
      sum_r    <= 16'h0000;
      colour_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      low_r    <= low_nxt;
      drop_r   <= drop_nxt;
      prev_r   <= prev_nxt;
      idx_r    <= idx_nxt;
      check_r  <= check_nxt;
      sum_r    <= sum_nxt;
      colour_r <= colour_nxt;
    end
  end

  // A dropped byte always falls where a low byte would be expected.
  a_drop_phase: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> !phase_r)
    else $error("byte drop armed in the middle of a word");

  a_field_index: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= vbfp_pkg::FIELD_LAST)
    else $error("field index out of range");

endmodule

// ----- rtl/vbfp_queue.sv -----
module vbfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vbfp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output vbfp_pkg::cmd_t pop_cmd
);

  vbfp_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign pop_cmd = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into a full queue");

endmodule

// ----- rtl/vbfp_back.sv -----
module vbfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  vbfp_pkg::cmd_t     q_cmd,
  output logic               pop,
  vbfp_out_if.source         out_bus
);

  logic [15:0]     field_r [4];
  logic            out_valid_r, out_valid_nxt;
  vbfp_pkg::kind_t kind_r;
  logic [15:0]     sig_r, pos_x_r, pos_y_r, width_r, height_r;
  logic            colour_r;
  logic            can_out;
  logic            is_field;
  logic            emit;

  assign can_out  = !out_valid_r || out_bus.ready;
  assign is_field = (q_cmd.op == vbfp_pkg::OP_FIELD);
  assign emit     = q_valid && !is_field && can_out;
  assign pop      = q_valid && (is_field || can_out);

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && is_field) begin
      field_r[q_cmd.idx[1:0]] <= q_cmd.word;
    end
    if (emit) begin
      colour_r <= q_cmd.colour;
      case (q_cmd.op)
        vbfp_pkg::OP_BLOCK: begin
          kind_r   <= vbfp_pkg::KIND_BLOCK;
          sig_r    <= field_r[0];
          pos_x_r  <= field_r[1];
          pos_y_r  <= field_r[2];
          width_r  <= field_r[3];
          height_r <= q_cmd.word;
        end
        default: begin
          case (q_cmd.op)
            vbfp_pkg::OP_END:    kind_r <= vbfp_pkg::KIND_END;
            vbfp_pkg::OP_CKERR:  kind_r <= vbfp_pkg::KIND_CKERR;
            default:             kind_r <= vbfp_pkg::KIND_SYNCERR;
          endcase
          sig_r    <= 16'h0000;
          pos_x_r  <= 16'h0000;
          pos_y_r  <= 16'h0000;
          width_r  <= 16'h0000;
          height_r <= 16'h0000;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.kind        = kind_r;
  assign out_bus.signature   = sig_r;
  assign out_bus.pos_x       = pos_x_r;
  assign out_bus.pos_y       = pos_y_r;
  assign out_bus.box_width   = width_r;
  assign out_bus.box_height  = height_r;
  assign out_bus.colour_code = colour_r;

  // A result command leaves the queue only into a free output register.
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("result command popped without reaching the output");

  a_field_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && is_field) |-> (q_cmd.idx < vbfp_pkg::FIELD_LAST))
    else $error("field command addresses the last field slot");

endmodule
